@@ sv/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg: shared types and codes of the directed cycle detector
// Item kinds, register indexes, sequencer states and the scan flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

    // Kind of an input transaction, carried on s_tuser.
    localparam logic [1:0] ACT_ADD_EDGE = 2'd0;
    localparam logic [1:0] ACT_RUN      = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    // Register index taken from paddr[2].
    localparam logic REG_NODE_COUNT = 1'b0;

    localparam int NODE_COUNT_W     = 7;
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_WR,
        ST_ROOT,
        ST_FETCH,
        ST_SCAN,
        ST_DECIDE,
        ST_POP,
        ST_EMIT
    } seq_state_t;

    // Flags produced by the row scan unit for the node on top of the stack.
    typedef struct packed {
        logic cycle_hit;
        logic cand_found;
    } scan_flags_t;

endpackage

`default_nettype wire

@@ sv/dcd_ram.sv @@
// ----------------------------------------------------------------------------
// dcd_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/dcd_row_scan.sv @@
// ----------------------------------------------------------------------------
// dcd_row_scan: shared row scan unit
// Masks one adjacency row, tests it against the on-path marks and picks the
// lowest unvisited successor. Results are registered for the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_row_scan #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                         clk,
    input  wire logic [MAX_NODES-1:0]         row,
    input  wire logic [MAX_NODES-1:0]         live,
    input  wire logic [MAX_NODES-1:0]         on_path,
    input  wire logic [MAX_NODES-1:0]         visited,
    output dcd_pkg::scan_flags_t              flags,
    output logic [$clog2(MAX_NODES)-1:0]      cand_idx
);

    localparam int NW = $clog2(MAX_NODES);

    logic [MAX_NODES-1:0] masked;
    logic [MAX_NODES-1:0] cand;
    logic [MAX_NODES-1:0] lowest;
    logic [NW-1:0]        idx_comb;
    dcd_pkg::scan_flags_t flags_comb;

    // Isolating the lowest set bit is a single wide two's complement add.
    assign masked = row & live;
    assign cand   = masked & ~visited;
    assign lowest = cand & (~cand + {{(MAX_NODES-1){1'b0}}, 1'b1});

    always_comb
    begin
        idx_comb = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (lowest[i])
            begin
                idx_comb = idx_comb | NW'(i);
            end
        end
        flags_comb.cycle_hit  = |(masked & on_path);
        flags_comb.cand_found = |cand;
    end

    always_ff @(posedge clk)
    begin
        flags    <= flags_comb;
        cand_idx <= idx_comb;
    end

endmodule

`default_nettype wire

@@ sv/directed_cycle_detect_core.sv @@
// ----------------------------------------------------------------------------
// directed_cycle_detect_core: directed graph cycle detector
// Holds a directed graph as an adjacency bit matrix in RAM and answers, per
// run transaction, whether the graph over the live nodes has a cycle.
// ----------------------------------------------------------------------------
// Usage. Input transactions arrive on s_tvalid/s_tready with the kind on
// s_tuser: add edge, run detection or clear graph. An add-edge transaction
// sets one matrix bit (ignored if either node is at or above the live node
// count): the row is read, then written back. A clear transaction sweeps
// the matrix RAM one row per cycle.
// A run transaction performs an iterative depth-first walk with an explicit
// stack held in a second RAM. The walk is driven by a small sequencer around
// one shared row scan unit: each root candidate is tested in turn, each push
// runs a row read, a scan and a decide step, and each pop does the same for
// the new stack top after reading it back from the stack RAM, unless the
// stack has emptied and the walk moves on to the next root candidate. The run
// stops early once a cycle is found. Exactly one result transaction
// (has_cycle in m_tdata bit 0) follows each run.
// The block takes one input transaction at a time and is not ready while a
// transaction is being worked on. The result sits in an output register, so
// a stalled receiver does not stop new transactions being taken; only a run
// finishing while an earlier result is still waiting holds until it drains.
// After reset the matrix RAM is swept clear before the first input
// transaction is accepted; node_count resets to 64 and can be written over
// the APB port at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_cycle_detect_core #(
    parameter int MAX_NODES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transaction channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [5:0] edge_from, [11:6] edge_to, [15:12] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] has_cycle, [7:1] zero
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CNT_W > dcd_pkg::NODE_COUNT_W) ? CNT_W : dcd_pkg::NODE_COUNT_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [dcd_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic                             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= dcd_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == dcd_pkg::REG_NODE_COUNT))
        begin
            node_count_reg <= pwdata[dcd_pkg::NODE_COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == dcd_pkg::REG_NODE_COUNT)
        begin
            prdata = 32'(node_count_reg);
        end
    end

    // The count saturates at MAX_NODES; live marks every node below it.
    logic [CMP_W-1:0]     n_count;
    logic [CMP_W-1:0]     n_live;
    logic [MAX_NODES-1:0] live;

    assign n_count = CMP_W'(node_count_reg);
    assign n_live  = (n_count > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : n_count;

    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            live[i] = (CMP_W'(i) < n_live);
        end
    end

    // ------------------------------------------------------------------
    // Memories: adjacency rows and the walk stack
    // ------------------------------------------------------------------
    logic                 adj_we;
    logic [NW-1:0]        adj_waddr;
    logic [MAX_NODES-1:0] adj_wdata;
    logic [NW-1:0]        adj_raddr;
    logic [MAX_NODES-1:0] adj_rdata;

    logic                 stk_we;
    logic [NW-1:0]        stk_waddr;
    logic [NW-1:0]        stk_wdata;
    logic [NW-1:0]        stk_raddr;
    logic [NW-1:0]        stk_rdata;

    dcd_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dcd_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------------
    // Shared row scan unit
    // ------------------------------------------------------------------
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [MAX_NODES-1:0] on_path_reg, on_path_next;
    dcd_pkg::scan_flags_t scan_flags;
    logic [NW-1:0]        scan_idx;

    dcd_row_scan #(
        .MAX_NODES (MAX_NODES)
    ) u_row_scan (
        .clk      (clk),
        .row      (adj_rdata),
        .live     (live),
        .on_path  (on_path_reg),
        .visited  (visited_reg),
        .flags    (scan_flags),
        .cand_idx (scan_idx)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    dcd_pkg::seq_state_t state_reg, state_next;
    logic [NW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]       from_reg, from_next;
    logic [NW-1:0]       to_reg, to_next;
    logic [NW-1:0]       top_reg, top_next;       // node on top of the stack
    logic [CMP_W-1:0]    depth_reg, depth_next;
    logic [CMP_W-1:0]    root_reg, root_next;
    logic                result_reg, result_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                has_cycle_reg, has_cycle_next;

    logic [5:0]          in_from;
    logic [5:0]          in_to;
    logic                in_accept;
    logic                edge_ok;
    logic                out_free;
    logic [CMP_W-1:0]    pop_idx;

    assign in_from   = s_tdata[5:0];
    assign in_to     = s_tdata[11:6];
    assign in_accept = s_tvalid && s_tready;
    assign edge_ok   = (CMP_W'(in_from) < n_live) && (CMP_W'(in_to) < n_live);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pop_idx   = depth_reg - CMP_W'(2);

    assign s_tready  = (state_reg == dcd_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'b0, has_cycle_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dcd_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            depth_reg    <= '0;
            root_reg     <= '0;
            visited_reg  <= '0;
            on_path_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            depth_reg    <= depth_next;
            root_reg     <= root_next;
            visited_reg  <= visited_next;
            on_path_reg  <= on_path_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg      <= from_next;
        to_reg        <= to_next;
        top_reg       <= top_next;
        result_reg    <= result_next;
        has_cycle_reg <= has_cycle_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        top_next       = top_reg;
        depth_next     = depth_reg;
        root_next      = root_reg;
        visited_next   = visited_reg;
        on_path_next   = on_path_reg;
        result_next    = result_reg;
        has_cycle_next = has_cycle_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        adj_we    = 1'b0;
        adj_waddr = from_reg;
        adj_wdata = adj_rdata | ({{(MAX_NODES-1){1'b0}}, 1'b1} << to_reg);
        adj_raddr = top_reg;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[NW-1:0];
        stk_wdata = scan_idx;
        stk_raddr = pop_idx[NW-1:0];

        unique case (state_reg)
            dcd_pkg::ST_CLEAR:
            begin
                adj_we    = 1'b1;
                adj_waddr = clr_cnt_reg;
                adj_wdata = '0;
                clr_cnt_next = clr_cnt_reg + NW'(1);
                if (clr_cnt_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = dcd_pkg::ST_IDLE;
                end
            end

            dcd_pkg::ST_IDLE:
            begin
                // Start the row read for an edge in the accepting cycle.
                adj_raddr = CMP_W'(in_from) >= CMP_W'(MAX_NODES) ? '0 : NW'(CMP_W'(in_from));
                if (in_accept)
                begin
                    unique case (s_tuser)
                        dcd_pkg::ACT_ADD_EDGE:
                        begin
                            if (edge_ok)
                            begin
                                from_next  = NW'(CMP_W'(in_from));
                                to_next    = NW'(CMP_W'(in_to));
                                state_next = dcd_pkg::ST_EDGE_WR;
                            end
                        end
                        dcd_pkg::ACT_RUN:
                        begin
                            visited_next = '0;
                            on_path_next = '0;
                            depth_next   = '0;
                            root_next    = '0;
                            state_next   = dcd_pkg::ST_ROOT;
                        end
                        dcd_pkg::ACT_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = dcd_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = dcd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            dcd_pkg::ST_EDGE_WR:
            begin
                adj_we     = 1'b1;
                state_next = dcd_pkg::ST_IDLE;
            end

            dcd_pkg::ST_ROOT:
            begin
                priority if (root_reg >= n_live)
                begin
                    result_next = 1'b0;
                    state_next  = dcd_pkg::ST_EMIT;
                end
                else if (visited_reg[root_reg[NW-1:0]])
                begin
                    root_next = root_reg + CMP_W'(1);
                end
                else
                begin
                    visited_next[root_reg[NW-1:0]] = 1'b1;
                    on_path_next[root_reg[NW-1:0]] = 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = root_reg[NW-1:0];
                    top_next   = root_reg[NW-1:0];
                    depth_next = CMP_W'(1);
                    state_next = dcd_pkg::ST_FETCH;
                end
            end

            dcd_pkg::ST_FETCH:
            begin
                adj_raddr  = top_reg;
                state_next = dcd_pkg::ST_SCAN;
            end

            dcd_pkg::ST_SCAN:
            begin
                state_next = dcd_pkg::ST_DECIDE;
            end

            dcd_pkg::ST_DECIDE:
            begin
                priority if (scan_flags.cycle_hit)
                begin
                    // An edge back onto the current path closes a cycle.
                    result_next = 1'b1;
                    depth_next  = '0;
                    state_next  = dcd_pkg::ST_EMIT;
                end
                else if (scan_flags.cand_found)
                begin
                    visited_next[scan_idx] = 1'b1;
                    on_path_next[scan_idx] = 1'b1;
                    stk_we     = 1'b1;
                    top_next   = scan_idx;
                    depth_next = depth_reg + CMP_W'(1);
                    state_next = dcd_pkg::ST_FETCH;
                end
                else
                begin
                    // No successor left: pop the node off the path.
                    on_path_next[top_reg] = 1'b0;
                    depth_next = depth_reg - CMP_W'(1);
                    if (depth_reg == CMP_W'(1))
                    begin
                        root_next  = root_reg + CMP_W'(1);
                        state_next = dcd_pkg::ST_ROOT;
                    end
                    else
                    begin
                        state_next = dcd_pkg::ST_POP;
                    end
                end
            end

            dcd_pkg::ST_POP:
            begin
                top_next   = stk_rdata;
                state_next = dcd_pkg::ST_FETCH;
            end

            dcd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    has_cycle_next = result_reg;
                    state_next     = dcd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dcd_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CMP_W'(MAX_NODES))
        else $error("walk stack depth exceeds the node limit");

    a_pop_has_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::ST_POP) |-> (depth_reg != '0))
        else $error("stack read back with an empty stack");

    a_top_on_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::ST_FETCH) |-> (on_path_reg[top_reg] && visited_reg[top_reg]))
        else $error("expanded node is not marked on the current path");

    a_hit_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::ST_DECIDE && scan_flags.cycle_hit)
        |=> (state_reg == dcd_pkg::ST_EMIT && result_reg))
        else $error("detected cycle not passed to the result stage");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(has_cycle_reg)))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire
